[hdl/wdst_pkg.sv]
// Shared types and constants for the watchdog subscriber table.
`timescale 1ns / 1ps

package wdst_pkg;

    // Mark held by a slot that has no subscriber.
    localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

    // Command opcodes.
    localparam logic [1:0] OP_SUBSCRIBE   = 2'd0;
    localparam logic [1:0] OP_UNSUBSCRIBE = 2'd1;
    localparam logic [1:0] OP_ALIVE       = 2'd2;
    localparam logic [1:0] OP_PERIOD_END  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL   = 2'd1;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;
    localparam logic [1:0] ST_SLOT_EMPTY   = 2'd3;

    // Command and partial result that walk down the row of slot cells.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] client_id;
        logic [7:0]  slot_number;
        logic        taken;
        logic [2:0]  granted_slot;
        logic        id_duplicate;
        logic [1:0]  status;
        logic        every_alive;
        logic [7:0]  silent_mask;
    } t_token;

endpackage

[hdl/watchdog_subscriber_table_core.sv]
// Top level of the watchdog subscriber table: command intake, slot cell row and result register.
`timescale 1ns / 1ps

// Channel  Dir  tdata                                         tuser
// s_axis   in   client_id[15:0] slot_number[23:16]            opcode[1:0]
// m_axis   out  granted_slot[2:0] id_duplicate[3]             status[1:0]
//               every_alive[4] silent_mask[12:5]
//
// A command walks the row of slot cells one cell per cycle unless the row is frozen,
// and its result is registered in the output register after the last cell. One
// command is in the row at a time, and a new one is accepted while the previous
// result still waits in the output register. A stalled output freezes the row
// once a command reaches the last cell. Reset empties all slots and clears all flags.

module watchdog_subscriber_table_core #(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // client_id[15:0], slot_number[23:16]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // granted_slot, id_duplicate, every_alive, silent_mask
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import wdst_pkg::*;

    t_token            tok [SLOT_COUNT+1];
    logic [SLOT_COUNT:0] vld;

    logic        r_busy;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic [1:0]  r_out_status;

    logic        accept;
    logic        en;
    logic        last_valid;
    t_token      last_tok;
    t_token      head_tok;
    logic [1:0]  fin_status;

    assign s_axis_tready = !r_busy;
    assign accept        = s_axis_tvalid && !r_busy;
    assign last_valid    = vld[SLOT_COUNT];
    assign last_tok      = tok[SLOT_COUNT];
    assign en            = !(last_valid && r_out_valid && !m_axis_tready);

    // Build the command token that enters the first cell.
    always_comb begin
        head_tok.opcode       = s_axis_tuser;
        head_tok.client_id    = s_axis_tdata[15:0];
        head_tok.slot_number  = s_axis_tdata[23:16];
        head_tok.taken        = 1'b0;
        head_tok.granted_slot = 3'd0;
        head_tok.id_duplicate = 1'b0;
        head_tok.every_alive  = 1'b1;
        head_tok.silent_mask  = 8'd0;
        head_tok.status       = ST_DONE;
        if (((s_axis_tuser == OP_UNSUBSCRIBE) || (s_axis_tuser == OP_ALIVE)) &&
            ({1'b0, s_axis_tdata[23:16]} >= 9'(SLOT_COUNT))) begin
            head_tok.status = ST_OUT_OF_RANGE;
        end
    end

    assign vld[0] = accept;
    assign tok[0] = head_tok;

    // Row of slot cells.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        wdst_cell #(
            .CELL_INDEX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(vld[g]),
            .i_tok  (tok[g]),
            .o_valid(vld[g+1]),
            .o_tok  (tok[g+1])
        );
    end

    // A subscribe that found no free slot reports a full table.
    always_comb begin
        fin_status = last_tok.status;
        if ((last_tok.opcode == OP_SUBSCRIBE) && !last_tok.taken) begin
            fin_status = ST_TABLE_FULL;
        end
    end

    // Busy flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (en && last_valid) begin
                r_busy <= 1'b0;
            end
            if (en && last_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (en && last_valid) begin
            r_out_status <= fin_status;
            r_out_data   <= {3'd0, last_tok.silent_mask, last_tok.every_alive,
                             last_tok.id_duplicate,
                             (last_tok.taken ? last_tok.granted_slot : 3'd0)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

[hdl/wdst_cell.sv]
// One slot of the subscriber table: holds an id and an alive flag and serves a passing command.
`timescale 1ns / 1ps

module wdst_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  wdst_pkg::t_token i_tok,
    output logic             o_valid,
    output wdst_pkg::t_token o_tok
);
    import wdst_pkg::*;

    localparam logic [2:0] SlotLow = 3'(CELL_INDEX % 8);
    localparam logic [7:0] SlotIdx = 8'(CELL_INDEX);
    localparam bit         InMask  = (CELL_INDEX < 8);

    logic [15:0] r_id;
    logic        r_alive;
    logic        r_valid;
    t_token      r_tok;

    logic [15:0] n_id;
    logic        n_alive;
    t_token      n_tok;
    logic        used;
    logic        rpt_alive;

    // Serve the command against this slot and fold the slot into the report.
    always_comb begin
        used    = (r_id != EMPTY_MARK);
        n_id    = r_id;
        n_alive = r_alive;
        n_tok   = i_tok;
        unique case (i_tok.opcode)
            OP_SUBSCRIBE: begin
                if (used && (r_id == i_tok.client_id)) begin
                    n_tok.id_duplicate = 1'b1;
                end
                if (!used && !i_tok.taken) begin
                    n_id               = i_tok.client_id;
                    n_alive            = 1'b1;
                    n_tok.taken        = 1'b1;
                    n_tok.granted_slot = SlotLow;
                end
            end
            OP_UNSUBSCRIBE, OP_ALIVE: begin
                if ((i_tok.status == ST_DONE) && (i_tok.slot_number == SlotIdx)) begin
                    if (!used) begin
                        n_tok.status = ST_SLOT_EMPTY;
                    end else if (i_tok.opcode == OP_UNSUBSCRIBE) begin
                        n_id    = EMPTY_MARK;
                        n_alive = 1'b0;
                    end else begin
                        n_alive = 1'b1;
                    end
                end
            end
            default: begin
                n_alive = 1'b0;
            end
        endcase
        // Period end reports the flags as they were before clearing.
        rpt_alive = (i_tok.opcode == OP_PERIOD_END) ? r_alive : n_alive;
        if ((n_id != EMPTY_MARK) && !rpt_alive) begin
            n_tok.every_alive = 1'b0;
            if (InMask) begin
                n_tok.silent_mask[SlotLow] = 1'b1;
            end
        end
    end

    // Slot state updates only when a command passes this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id    <= EMPTY_MARK;
            r_alive <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_id    <= n_id;
                r_alive <= n_alive;
            end
        end
    end

    // Hand the partial result to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_tok <= n_tok;
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the watchdog subscriber table core.
`timescale 1ns / 1ps

module tb_top;
    import wdst_pkg::*;

    localparam int NSLOTS     = 8;
    localparam int LONG_HOLD  = 80;
    localparam int DRAIN_WAIT = NSLOTS + 4;

    // One predicted result beat, fields as they appear on the result port.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] granted_slot;
        logic       id_duplicate;
        logic       every_alive;
        logic [7:0] silent_mask;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // client_id[15:0], slot_number[23:16]
    logic [1:0]  s_axis_tuser;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // granted_slot[2:0], id_duplicate[3], every_alive[4],
                                 // silent_mask[12:5], zero pad[15:13]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    // Predicted copy of the slot table.
    logic [15:0] slot_id_copy [NSLOTS];
    logic        alive_copy   [NSLOTS];

    t_result     awaited_results[$];
    int          mismatch_count;
    int          idle_pct;
    int          hold_requests;
    int          hold_served;
    int          hold_left;
    int          stall_left;
    logic [15:0] id_pool [6];

    watchdog_subscriber_table_core #(
        .SLOT_COUNT(NSLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 12 ns period.
    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Give up if the run hangs.
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Apply one command to the predicted table and return the result it should give.
    function automatic t_result predict_command(input logic [1:0] op, input logic [15:0] id,
                                                input logic [7:0] idx);
        t_result r;
        int      free_slot;
        r = '0;
        free_slot = -1;
        case (op)
            OP_SUBSCRIBE: begin
                for (int i = 0; i < NSLOTS; i++) begin
                    if (slot_id_copy[i[2:0]] != EMPTY_MARK && slot_id_copy[i[2:0]] == id)
                        r.id_duplicate = 1'b1;
                    if (free_slot < 0 && slot_id_copy[i[2:0]] == EMPTY_MARK)
                        free_slot = i;
                end
                if (free_slot < 0) begin
                    r.status = ST_TABLE_FULL;
                end else begin
                    slot_id_copy[free_slot[2:0]] = id;
                    alive_copy[free_slot[2:0]]   = 1'b1;
                    r.granted_slot               = free_slot[2:0];
                end
            end
            OP_UNSUBSCRIBE, OP_ALIVE: begin
                if (idx >= NSLOTS) begin
                    r.status = ST_OUT_OF_RANGE;
                end else if (slot_id_copy[idx[2:0]] == EMPTY_MARK) begin
                    r.status = ST_SLOT_EMPTY;
                end else if (op == OP_UNSUBSCRIBE) begin
                    slot_id_copy[idx[2:0]] = EMPTY_MARK;
                    alive_copy[idx[2:0]]   = 1'b0;
                end else begin
                    alive_copy[idx[2:0]] = 1'b1;
                end
            end
            default: ;
        endcase

        // The report reflects the table before a period end clears the flags.
        r.every_alive = 1'b1;
        for (int i = 0; i < NSLOTS; i++) begin
            if (slot_id_copy[i[2:0]] != EMPTY_MARK && !alive_copy[i[2:0]]) begin
                r.every_alive           = 1'b0;
                r.silent_mask[i[2:0]]   = 1'b1;
            end
        end
        if (op == OP_PERIOD_END) begin
            for (int i = 0; i < NSLOTS; i++)
                alive_copy[i[2:0]] = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Offer one command beat and wait until the block takes it.
    task automatic send_command(input logic [1:0] op, input logic [15:0] id,
                                input logic [7:0] idx);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, id};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        awaited_results.push_back(predict_command(op, id, idx));
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic wait_until_drained;
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Random commands; sub_pct steers how fast the table fills.
    task automatic send_random_batch(input int count, input int sub_pct);
        logic [1:0]  op;
        logic [15:0] id;
        logic [7:0]  idx;
        int          pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < sub_pct) begin
                op = OP_SUBSCRIBE;
            end else begin
                pick = $urandom_range(7);
                op = (pick < 4) ? OP_ALIVE : (pick < 6) ? OP_UNSUBSCRIBE : OP_PERIOD_END;
            end
            pick = $urandom_range(99);
            if (pick < 40)
                id = id_pool[3'($urandom_range(5))];
            else if (pick < 97)
                id = 16'($urandom_range(0, 65534));
            else
                id = EMPTY_MARK;
            if ($urandom_range(99) < 88)
                idx = 8'($urandom_range(0, NSLOTS - 1));
            else
                idx = 8'($urandom_range(NSLOTS, 255));
            send_command(op, id, idx);
        end
    endtask

    // Result side: check each beat and randomize the ready signal.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                t_result want;
                want = awaited_results.pop_front();
                check_field("status", int'(want.status), int'(m_axis_tuser));
                check_field("granted_slot", int'(want.granted_slot),
                            int'(m_axis_tdata[2:0]));
                check_field("id_duplicate", int'(want.id_duplicate),
                            int'(m_axis_tdata[3]));
                check_field("every_alive", int'(want.every_alive), int'(m_axis_tdata[4]));
                check_field("silent_mask", int'(want.silent_mask),
                            int'(m_axis_tdata[12:5]));
                check_field("tdata pad", 0, int'(m_axis_tdata[15:13]));
            end
        end

        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct / 2) begin
            stall_left = $urandom_range(1, 6) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Corner cases of every opcode, starting from the empty table.
    task automatic test_directed;
        idle_pct = 30;
        send_command(OP_PERIOD_END, 16'h0000, 8'd0);
        send_command(OP_ALIVE, 16'h0000, 8'd0);
        send_command(OP_UNSUBSCRIBE, 16'hFFFF, 8'd7);
        send_command(OP_UNSUBSCRIBE, 16'h0000, 8'd8);
        send_command(OP_ALIVE, 16'hFFFF, 8'd255);
        send_command(OP_SUBSCRIBE, 16'h0000, 8'd0);
        send_command(OP_SUBSCRIBE, 16'hFFFE, 8'd255);
        // Same id again still takes a slot but is marked as a duplicate.
        send_command(OP_SUBSCRIBE, 16'h0000, 8'd0);
        // The reserved id is written as the empty mark, so the slot stays free.
        send_command(OP_SUBSCRIBE, EMPTY_MARK, 8'd0);
        send_command(OP_PERIOD_END, 16'h1234, 8'd99);
        send_command(OP_ALIVE, 16'h0000, 8'd1);
        send_command(OP_PERIOD_END, 16'h0000, 8'd0);
        send_command(OP_SUBSCRIBE, 16'h00FF, 8'd0);
        send_command(OP_SUBSCRIBE, 16'hFF00, 8'd0);
        send_command(OP_SUBSCRIBE, 16'h5A5A, 8'd0);
        send_command(OP_SUBSCRIBE, 16'hA5A5, 8'd0);
        send_command(OP_SUBSCRIBE, 16'h8001, 8'd0);
        // Table is full now: once with a fresh id, once with a duplicate.
        send_command(OP_SUBSCRIBE, 16'h7FFF, 8'd0);
        send_command(OP_SUBSCRIBE, 16'hFFFE, 8'd0);
        send_command(OP_UNSUBSCRIBE, 16'h0000, 8'd4);
        send_command(OP_UNSUBSCRIBE, 16'h0000, 8'd4);
        send_command(OP_ALIVE, 16'hFFFF, 8'd7);
        send_command(OP_PERIOD_END, 16'hFFFF, 8'd255);
        send_command(OP_SUBSCRIBE, 16'h1357, 8'd255);
        send_command(OP_UNSUBSCRIBE, EMPTY_MARK, 8'd0);
    endtask

    // Receiver holds off for a long stretch while commands keep coming.
    task automatic test_output_backpressure;
        idle_pct = 0;
        hold_requests <= hold_requests + 1;
        send_random_batch(25, 40);
        idle_pct = 30;
    endtask

    // Sender pauses until the block has answered everything, then resumes.
    task automatic test_pause_and_resume;
        send_random_batch(10, 50);
        wait_until_drained();
        send_random_batch(10, 30);
    endtask

    // Long random traffic in segments that swing the table between empty and full.
    task automatic test_random_traffic;
        int rate_pick;
        for (int seg = 0; seg < 11; seg++) begin
            rate_pick = $urandom_range(2);
            idle_pct = (rate_pick == 0) ? 0 : (rate_pick == 1) ? 25 : 50;
            send_random_batch(100, $urandom_range(10, 70));
        end
    endtask

    // Back-to-back traffic with both sides always ready.
    task automatic test_steady_stream;
        idle_pct = 0;
        send_random_batch(200, 35);
    endtask

    // Main sequence.
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SUBSCRIBE;
        m_axis_tready <= 1'b0;
        mismatch_count = 0;
        idle_pct       = 30;
        hold_requests  = 0;
        hold_served    = 0;
        hold_left      = 0;
        stall_left     = 0;
        for (int i = 0; i < NSLOTS; i++) begin
            slot_id_copy[i[2:0]] = EMPTY_MARK;
            alive_copy[i[2:0]]   = 1'b0;
        end
        for (int i = 0; i < 6; i++)
            id_pool[i[2:0]] = 16'($urandom_range(0, 65534));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_backpressure();
        test_pause_and_resume();
        test_random_traffic();
        test_steady_stream();

        wait_until_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
